@@ design/utf8_to_latin1_filter_assert.svh @@
// ---------------------------------------------------------------------------
// utf8_to_latin1_filter assertion macros
// Shared property forms for the filter's checker.
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_LATIN1_FILTER_ASSERT_SVH
`define UTF8_TO_LATIN1_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define U2L_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("utf8_to_latin1_filter: same-cycle property failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define U2L_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("utf8_to_latin1_filter: next-cycle property failed");

`endif

@@ design/utf8l_pkg.sv @@
// ---------------------------------------------------------------------------
// utf8l_pkg
// Request and result types, code point constants and the punctuation map.
// ---------------------------------------------------------------------------
package utf8l_pkg;

    localparam int unsigned CP_W = 21;

    typedef logic [CP_W-1:0] cp_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] latin1_char;
        logic       char_valid;
        logic       text_done;
    } out_item_t;

    localparam cp_t CP_BULLET       = 21'h02022;
    localparam cp_t CP_HYPHEN_POINT = 21'h02027;
    localparam cp_t CP_ONE_DOT      = 21'h02024;
    localparam cp_t CP_DASH_FIRST   = 21'h02010;
    localparam cp_t CP_DASH_LAST    = 21'h02015;
    localparam cp_t CP_TWO_DOT      = 21'h02025;
    localparam cp_t CP_SQUOTE_FIRST = 21'h02018;
    localparam cp_t CP_SQUOTE_LAST  = 21'h0201B;
    localparam cp_t CP_DQUOTE_FIRST = 21'h0201C;
    localparam cp_t CP_DQUOTE_LAST  = 21'h0201F;
    localparam cp_t LATIN1_LIMIT    = 21'h00100;

    localparam cp_t CH_MIDDLE_DOT = 21'h000B7;
    localparam cp_t CH_HYPHEN     = 21'h0002D;
    localparam cp_t CH_DIAERESIS  = 21'h000A8;
    localparam cp_t CH_APOSTROPHE = 21'h00027;
    localparam cp_t CH_QUOTE      = 21'h00022;

    // Map typographic punctuation to a Latin-1 stand-in.
    function automatic cp_t substitute(input cp_t cp);
        cp_t res;
        res = cp;
        if (cp inside {CP_BULLET, CP_HYPHEN_POINT, CP_ONE_DOT}) begin
            res = CH_MIDDLE_DOT;
        end else if (cp inside {[CP_DASH_FIRST:CP_DASH_LAST]}) begin
            res = CH_HYPHEN;
        end else if (cp == CP_TWO_DOT) begin
            res = CH_DIAERESIS;
        end else if (cp inside {[CP_SQUOTE_FIRST:CP_SQUOTE_LAST]}) begin
            res = CH_APOSTROPHE;
        end else if (cp inside {[CP_DQUOTE_FIRST:CP_DQUOTE_LAST]}) begin
            res = CH_QUOTE;
        end
        return res;
    endfunction

endpackage

@@ design/utf8_to_latin1_filter.sv @@
// ---------------------------------------------------------------------------
// utf8_to_latin1_filter
// UTF-8 byte stream to Latin-1 characters, one result per input byte.
// ---------------------------------------------------------------------------
// Takes one byte per cycle while the result side does not stall and returns
// exactly one result per byte: the byte lands in an input register, the
// decode and punctuation map run in one combinational step against the
// sequence state, and the result is held in an output register. Sustained
// rate is one byte per clock unless the result side stalls; the only loop is
// the sequence state, updated once per byte as it leaves the input register.
// char_valid is low (and latin1_char zero) for lead and continuation bytes
// that do not finish a code point, for code points at or above 0x100 after
// the map, and for stray or invalid bytes. end_of_text clears the state.
module utf8_to_latin1_filter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  utf8l_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output utf8l_pkg::out_item_t  m_data
);
    import utf8l_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t dec_result;
    logic      advance;

    // move the held request to the result register when that slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    utf8l_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .result  (dec_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= dec_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ design/utf8l_decoder.sv @@
// ---------------------------------------------------------------------------
// utf8l_decoder
// Sequence state (bytes owed, partial code point) and the per-byte decode.
// ---------------------------------------------------------------------------
module utf8l_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  utf8l_pkg::in_item_t item,
    output utf8l_pkg::out_item_t result
);
    import utf8l_pkg::*;

    logic [1:0] owed_reg, owed_next;
    cp_t        part_reg, part_next;
    cp_t        shifted;
    cp_t        cp;
    cp_t        sub_cp;
    logic       complete;
    logic       emit;
    logic [7:0] b;

    assign b       = item.text_byte;
    assign shifted = {part_reg[CP_W-7:0], b[5:0]};

    always_comb begin
        owed_next = owed_reg;
        part_next = part_reg;
        complete  = 1'b0;
        cp        = '0;
        if (owed_reg == 2'd0) begin
            if (b[7] == 1'b0) begin
                cp       = {13'd0, b};
                complete = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                part_next = {16'd0, b[4:0]};
                owed_next = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                part_next = {17'd0, b[3:0]};
                owed_next = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                part_next = {18'd0, b[2:0]};
                owed_next = 2'd3;
            end
            // stray continuation or invalid lead: drop
        end else begin
            owed_next = owed_reg - 2'd1;
            if (owed_reg == 2'd1) begin
                cp        = shifted;
                complete  = 1'b1;
                part_next = '0;
            end else begin
                part_next = shifted;
            end
        end
        // end of text clears any cut-off sequence
        if (item.end_of_text) begin
            owed_next = 2'd0;
            part_next = '0;
        end
    end

    assign sub_cp = substitute(cp);
    assign emit   = complete && (sub_cp < LATIN1_LIMIT);

    always_comb begin
        result.latin1_char = emit ? sub_cp[7:0] : 8'd0;
        result.char_valid  = emit;
        result.text_done   = item.end_of_text;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg <= 2'd0;
            part_reg <= '0;
        end else if (advance) begin
            owed_reg <= owed_next;
            part_reg <= part_next;
        end
    end

endmodule

@@ design/utf8l_checker.sv @@
// ---------------------------------------------------------------------------
// utf8l_checker
// Port-level checks on the filter, bound to every instance of the top level.
// ---------------------------------------------------------------------------
`include "utf8_to_latin1_filter_assert.svh"

module utf8l_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input utf8l_pkg::in_item_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input utf8l_pkg::out_item_t m_data
);
    import utf8l_pkg::*;

    // a waiting request holds
    `U2L_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_data))

    // a stalled result holds
    `U2L_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // no character means a zero character
    `U2L_ASSERT_NOW(a_char_zero, m_valid && !m_data.char_valid, m_data.latin1_char == 8'd0)

    // an empty result register never back-pressures the input
    `U2L_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)

endmodule

bind utf8_to_latin1_filter utf8l_checker u_utf8l_checker (.*);

@@ verif/utf8_to_latin1_filter_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_to_latin1_filter_checker
// Watches both channels of the filter, predicts each result from the accepted
// requests and compares it field by field with what the filter returns.
// ---------------------------------------------------------------------------
module utf8_to_latin1_filter_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  utf8l_pkg::in_item_t   s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  utf8l_pkg::out_item_t  m_data,
    output int                    mismatches,
    output int                    chars_pending,
    output int                    results_checked,
    output int                    chars_emitted
);
    import utf8l_pkg::*;

    localparam cp_t BULLET_CP      = 21'h02022;
    localparam cp_t ONE_DOT_CP     = 21'h02024;
    localparam cp_t TWO_DOT_CP     = 21'h02025;
    localparam cp_t HYPH_POINT_CP  = 21'h02027;
    localparam cp_t DASH_LO_CP     = 21'h02010;
    localparam cp_t DASH_HI_CP     = 21'h02015;
    localparam cp_t SQUOTE_LO_CP   = 21'h02018;
    localparam cp_t SQUOTE_HI_CP   = 21'h0201B;
    localparam cp_t DQUOTE_LO_CP   = 21'h0201C;
    localparam cp_t DQUOTE_HI_CP   = 21'h0201F;
    localparam cp_t LATIN1_END_CP  = 21'h00100;
    localparam cp_t MID_DOT_CH     = 21'h000B7;
    localparam cp_t MINUS_CH       = 21'h0002D;
    localparam cp_t DIAERESIS_CH   = 21'h000A8;
    localparam cp_t APOS_CH        = 21'h00027;
    localparam cp_t DQUOTE_CH      = 21'h00022;

    logic [1:0]  cont_owed;
    cp_t         cp_accum;
    out_item_t   expected_chars[$];
    int          n_bad;
    int          n_checked;
    int          n_chars;

    assign mismatches      = n_bad;
    assign chars_pending   = expected_chars.size();
    assign results_checked = n_checked;
    assign chars_emitted   = n_chars;

    initial begin
        cont_owed = '0;
        cp_accum  = '0;
        n_bad     = 0;
        n_checked = 0;
        n_chars   = 0;
    end

    function automatic cp_t latin1_stand_in(input cp_t cp);
        if (cp == BULLET_CP || cp == ONE_DOT_CP || cp == HYPH_POINT_CP) begin
            return MID_DOT_CH;
        end
        if (cp >= DASH_LO_CP && cp <= DASH_HI_CP) begin
            return MINUS_CH;
        end
        if (cp == TWO_DOT_CP) begin
            return DIAERESIS_CH;
        end
        if (cp >= SQUOTE_LO_CP && cp <= SQUOTE_HI_CP) begin
            return APOS_CH;
        end
        if (cp >= DQUOTE_LO_CP && cp <= DQUOTE_HI_CP) begin
            return DQUOTE_CH;
        end
        return cp;
    endfunction

    // Advance the sequence state by one byte and return the result it causes.
    function automatic out_item_t decode_byte(input in_item_t req);
        out_item_t res;
        cp_t       cp;
        logic      complete;
        res      = '0;
        cp       = '0;
        complete = 1'b0;
        if (cont_owed == 2'd0) begin
            if (!req.text_byte[7]) begin
                cp       = cp_t'(req.text_byte);
                complete = 1'b1;
            end else if (req.text_byte[7:5] == 3'b110) begin
                cp_accum  = cp_t'(req.text_byte[4:0]);
                cont_owed = 2'd1;
            end else if (req.text_byte[7:4] == 4'b1110) begin
                cp_accum  = cp_t'(req.text_byte[3:0]);
                cont_owed = 2'd2;
            end else if (req.text_byte[7:3] == 5'b11110) begin
                cp_accum  = cp_t'(req.text_byte[2:0]);
                cont_owed = 2'd3;
            end
            // stray continuation and invalid lead bytes fall through: no character
        end else begin
            // any byte counts as a continuation here, top two bits ignored
            cp_accum  = {cp_accum[CP_W-7:0], req.text_byte[5:0]};
            cont_owed = cont_owed - 2'd1;
            if (cont_owed == 2'd0) begin
                cp       = cp_accum;
                complete = 1'b1;
                cp_accum = '0;
            end
        end
        if (req.end_of_text) begin
            cont_owed = '0;
            cp_accum  = '0;
        end
        if (complete) begin
            cp = latin1_stand_in(cp);
            if (cp < LATIN1_END_CP) begin
                res.latin1_char = cp[7:0];
                res.char_valid  = 1'b1;
            end
        end
        res.text_done = req.end_of_text;
        return res;
    endfunction

    task automatic log_bad(input string what, input out_item_t want, input out_item_t got);
        n_bad++;
        if (n_bad <= 10) begin
            $display("[%0t] %s: expected char=%02h valid=%b done=%b, got char=%02h valid=%b done=%b",
                     $realtime, what, want.latin1_char, want.char_valid, want.text_done,
                     got.latin1_char, got.char_valid, got.text_done);
        end
    endtask

    always @(posedge aclk) begin : watch
        out_item_t want;
        out_item_t got;
        if (!aresetn) begin
            cont_owed = '0;
            cp_accum  = '0;
            expected_chars.delete();
        end else begin
            // results can only belong to requests accepted at earlier edges
            if (m_valid && m_ready) begin
                got = m_data;
                n_checked++;
                if (got.char_valid === 1'b1) begin
                    n_chars++;
                end
                if (expected_chars.size() == 0) begin
                    log_bad("result with no request outstanding", '0, got);
                end else begin
                    want = expected_chars.pop_front();
                    if (got.latin1_char !== want.latin1_char
                        || got.char_valid !== want.char_valid
                        || got.text_done !== want.text_done) begin
                        log_bad("result mismatch", want, got);
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_chars.push_back(decode_byte(s_data));
            end
        end
    end

endmodule

@@ verif/tb_utf8_to_latin1_filter.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_utf8_to_latin1_filter
// Byte stream stimulus for the UTF-8 to Latin-1 filter.
// ---------------------------------------------------------------------------
// Drives a directed set of sequences (ASCII ends, two, three and four byte
// code points, three punctuation stand-ins, stray and invalid bytes, unchecked
// continuations, overlong forms, a sequence cut off at end of text), then
// mostly well-formed random text mixed with noise and broken sequences.
// Both sides idle at random; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_utf8_to_latin1_filter;
    import utf8l_pkg::*;

    localparam int RANDOM_BYTES  = 700;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int mismatches;
    int chars_pending;
    int results_checked;
    int chars_emitted;

    int bytes_sent    = 0;
    int strings_ended = 0;
    int directed_sent = 0;
    int tx_idle_max   = 15;
    int rx_idle_max   = 15;
    int quiet_cycles  = 0;

    utf8_to_latin1_filter i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    utf8_to_latin1_filter_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatches      (mismatches),
        .chars_pending   (chars_pending),
        .results_checked (results_checked),
        .chars_emitted   (chars_emitted)
    );

    always #4 aclk = ~aclk;

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid            = 1'b1;
        s_data.text_byte   = b;
        s_data.end_of_text = eot;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
        if (eot) begin
            strings_ended++;
        end
        if (bytes_sent % 40 == 0) begin
            tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
        end
    endtask

    // Encode cp as an n-byte sequence, sending only the lead and keep continuations.
    task automatic send_seq(input logic [20:0] cp, input int n, input int keep,
                            input logic eot_last);
        logic [7:0] lead;
        logic [7:0] cont;
        logic [1:0] top;
        case (n)
            2:       lead = {3'b110, cp[10:6]};
            3:       lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        send_byte(lead, eot_last && keep == 0);
        for (int k = 1; k <= keep; k++) begin
            // now and then a continuation with a wrong marker, which must still be taken
            top  = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
            cont = {top, 6'((cp >> (6 * (n - 1 - k))) & 21'h3F)};
            send_byte(cont, eot_last && k == keep);
        end
    endtask

    initial begin
        int pick;
        int n;
        logic eot_last;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ASCII extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // two-byte inside and just past Latin-1
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hC4, 1'b0);
        send_byte(8'h80, 1'b0);
        // bullet, two-dot leader, left double quote
        send_byte(8'hE2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hA2, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h9C, 1'b0);
        // stray continuation, invalid lead
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // continuation byte without its marker bits
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        // overlong four-byte form of 'A', ending the string
        send_byte(8'hF0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h81, 1'b1);
        // sequence cut off at end of text
        send_byte(8'hE2, 1'b0);
        send_byte(8'h80, 1'b1);
        directed_sent = bytes_sent;

        while (bytes_sent < directed_sent + RANDOM_BYTES) begin
            pick     = $urandom_range(0, 99);
            eot_last = ($urandom_range(0, 11) == 0);
            if (pick < 30) begin
                send_byte(8'($urandom_range(0, 127)), eot_last);
            end else if (pick < 50) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_seq(21'($urandom_range(8'h80, 8'hFF)), 2, 1, eot_last);
                end else begin
                    send_seq(21'($urandom_range(0, 11'h7FF)), 2, 1, eot_last);
                end
            end else if (pick < 72) begin
                // punctuation block and its neighbors
                send_seq(21'($urandom_range(16'h200C, 16'h202B)), 3, 2, eot_last);
            end else if (pick < 80) begin
                send_seq(21'($urandom_range(0, 16'hFFFF)), 3, 2, eot_last);
            end else if (pick < 87) begin
                send_seq(21'($urandom_range(0, 21'h1FFFFF)), 4, 3, eot_last);
            end else if (pick < 95) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end else begin
                // drop the tail of a sequence; the next lead byte fills in or text ends
                n = $urandom_range(2, 4);
                send_seq(21'($urandom_range(0, 21'h1FFFFF)), n, $urandom_range(0, n - 2),
                         $urandom_range(0, 1) == 1);
            end
        end
        s_valid = 1'b0;

        while (chars_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d bytes (%0d directed) across %0d ended strings.",
                 bytes_sent, directed_sent, strings_ended);
        $display("Compared %0d results, %0d of them carrying a Latin-1 character.",
                 results_checked, chars_emitted);
        if (mismatches == 0 && chars_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Result side: hold off a random number of cycles before taking each result.
    initial begin
        int gap;
        int taken;
        taken   = 0;
        m_ready = 1'b0;
        do @(negedge aclk); while (aresetn !== 1'b1);
        forever begin
            gap = $urandom_range(0, rx_idle_max);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
            taken++;
            if (taken % 40 == 0) begin
                rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without a transfer", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
